[sv/drt_pkg.sv]
// ----------------------------------------------------------------------------
// drt_pkg
// shared types, constants and helpers of the drift tracking rescaler
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int DATA_W           = 32;
   localparam int FRAC_W           = 16;
   localparam int DEF_MAX_UPSAMPLE = 16;
   localparam int DEF_COUNTER_BITS = 16;
   localparam int INTERVAL_W       = 16;
   localparam int FACTOR_W         = 5;
   localparam int ADDR_W           = 5;
   localparam int WIDE_W           = 64;
   // divider: dividend magnitude is a 33-bit range shifted by the fraction
   localparam int DIVD_W           = DATA_W + 1 + FRAC_W;
   localparam int DIVS_W           = DATA_W + 1;

   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // reset register values
   localparam logic signed [DATA_W-1:0] RST_MODEL_MIN = DATA_W'(0);
   localparam logic signed [DATA_W-1:0] RST_MODEL_MAX = DATA_W'(65536);
   localparam logic signed [DATA_W-1:0] RST_REAL_MIN  = DATA_W'(0);
   localparam logic signed [DATA_W-1:0] RST_REAL_MAX  = DATA_W'(65536);
   localparam logic [INTERVAL_W-1:0]    RST_INTERVAL  = INTERVAL_W'(2);
   localparam logic [FACTOR_W-1:0]      RST_FACTOR    = FACTOR_W'(1);
   // factors derived from the reset ranges
   localparam logic signed [DATA_W-1:0] RST_GAIN      = DATA_W'(65536);
   localparam logic signed [DATA_W-1:0] RST_BIAS      = DATA_W'(0);

   // register indexes
   localparam logic [2:0] CSR_MODEL_MIN = 3'd0;
   localparam logic [2:0] CSR_MODEL_MAX = 3'd1;
   localparam logic [2:0] CSR_REAL_MIN  = 3'd2;
   localparam logic [2:0] CSR_REAL_MAX  = 3'd3;
   localparam logic [2:0] CSR_INTERVAL  = 3'd4;
   localparam logic [2:0] CSR_DRIFT_EN  = 3'd5;
   localparam logic [2:0] CSR_FACTOR    = 3'd6;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     first;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     interpolated;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] model_min;
      logic signed [DATA_W-1:0] model_max;
      logic signed [DATA_W-1:0] real_min;
      logic signed [DATA_W-1:0] real_max;
      logic [INTERVAL_W-1:0]    recal_interval;
      logic                     drift_enable;
      logic [FACTOR_W-1:0]      upsample_factor;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_FAC_START,
      OP_FAC_ZERO,
      OP_FAC_GAIN,
      OP_MUL,
      OP_FAC_BIAS,
      OP_WIN,
      OP_CHECK,
      OP_SMUL_SET,
      OP_SCALE,
      OP_DIFF_START,
      OP_DIFF_DONE,
      OP_EMIT_PT,
      OP_EMIT_LAST
   } dp_op_type;

   typedef struct packed {
      logic rr_zero;
      logic due;
      logic need_interp;
      logic last_pt;
      logic out_free;
      logic div_done;
   } dp_status_type;

   function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(VAL_MAX);
      lo = WIDE_W'(VAL_MIN);
      if (v > hi) begin
         return VAL_MAX;
      end else if (v < lo) begin
         return VAL_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

[sv/drift_tracking_rescaler_upsampler.sv]
// ----------------------------------------------------------------------------
// drift_tracking_rescaler_upsampler
// rescales Q16.16 samples into the model range and upsamples them
// ----------------------------------------------------------------------------
// req channel takes one word per sample (sample, first). rsp channel gives
// upsample_factor - 1 interpolated words, then the scaled sample with last.
// first reloads gain and bias from the range registers and drops the
// previous sample, so that word yields only the scaled sample.
// with no factor load and drift off, SMUL_SET, SMUL, SCALE, DIFF_START and
// EMIT_LAST follow accept and put the final word in the output register.
// drift tracking adds WIN and CHECK; a factor load (record start or drift
// recalculation) adds FAC_START, DIV_WAIT on the 49-step serial divider,
// FAC_GAIN, FAC_MUL and FAC_BIAS. interpolation adds a divider pass, then
// one word per cycle while the receiver does not stall. req_stall is high
// from accept until the final word is registered: one sample in flight.
// reset sets registers to their defaults (gain 1.0, bias 0) and empties the
// drift window. when the receiver stalls, the output register holds its word
// and the sequencer waits; nothing is dropped.
// the csr port is written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module drift_tracking_rescaler_upsampler
   import drt_pkg::*;
#(
   parameter int MAX_UPSAMPLE = DEF_MAX_UPSAMPLE,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type       cfg_ff;
   logic          wr_en;
   logic [2:0]    idx;
   dp_op_type     cmd;
   dp_status_type status;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.model_min       <= RST_MODEL_MIN;
         cfg_ff.model_max       <= RST_MODEL_MAX;
         cfg_ff.real_min        <= RST_REAL_MIN;
         cfg_ff.real_max        <= RST_REAL_MAX;
         cfg_ff.recal_interval  <= RST_INTERVAL;
         cfg_ff.drift_enable    <= 1'b0;
         cfg_ff.upsample_factor <= RST_FACTOR;
      end else if (wr_en) begin
         case (idx)
            CSR_MODEL_MIN: cfg_ff.model_min       <= pwdata;
            CSR_MODEL_MAX: cfg_ff.model_max       <= pwdata;
            CSR_REAL_MIN:  cfg_ff.real_min        <= pwdata;
            CSR_REAL_MAX:  cfg_ff.real_max        <= pwdata;
            CSR_INTERVAL:  cfg_ff.recal_interval  <= pwdata[INTERVAL_W-1:0];
            CSR_DRIFT_EN:  cfg_ff.drift_enable    <= pwdata[0];
            CSR_FACTOR:    cfg_ff.upsample_factor <= pwdata[FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_MODEL_MIN: prdata = cfg_ff.model_min;
         CSR_MODEL_MAX: prdata = cfg_ff.model_max;
         CSR_REAL_MIN:  prdata = cfg_ff.real_min;
         CSR_REAL_MAX:  prdata = cfg_ff.real_max;
         CSR_INTERVAL:  prdata = 32'(cfg_ff.recal_interval);
         CSR_DRIFT_EN:  prdata = 32'(cfg_ff.drift_enable);
         CSR_FACTOR:    prdata = 32'(cfg_ff.upsample_factor);
         default:       prdata = '0;
      endcase
   end

   drt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_first   (req_data.first),
      .drift_enable(cfg_ff.drift_enable),
      .status      (status),
      .cmd         (cmd),
      .req_stall   (req_stall)
   );

   drt_dp #(
      .MAX_UPSAMPLE(MAX_UPSAMPLE),
      .COUNTER_BITS(COUNTER_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .status   (status)
   );

endmodule

[sv/drt_div.sv]
// ----------------------------------------------------------------------------
// drt_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module drt_div
   import drt_pkg::*;
#(
   parameter int DW = DIVD_W,
   parameter int VW = DIVS_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = VW'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[sv/drt_dp.sv]
// ----------------------------------------------------------------------------
// drt_dp
// datapath: factors, drift window, scaling multiplier, interpolation, output
// ----------------------------------------------------------------------------
module drt_dp
   import drt_pkg::*;
#(
   parameter int MAX_UPSAMPLE = DEF_MAX_UPSAMPLE,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_op_type     cmd,
   input  req_type       req_data,
   input  cfg_type       cfg,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   output dp_status_type status
);

   localparam int UW = $clog2(MAX_UPSAMPLE + 1);
   localparam int QW = DATA_W + 2;
   localparam int CB = COUNTER_BITS;

   logic signed [DATA_W-1:0] smp_ff, gain_ff, bias_ff, wl_ff, wh_ff;
   logic signed [DATA_W-1:0] prev_ff, scaled_ff, rlo_ff, rhi_ff, gnew_ff;
   logic signed [DATA_W-1:0] ma_ff, mb_ff;
   logic signed [WIDE_W-1:0] prod_ff;
   logic                     have_prev_ff, neg_ff;
   logic [CB-1:0]            cnt_ff;
   logic signed [QW-1:0]     dq_ff, q_ff;
   logic [UW-1:0]            dr_ff, r_ff, j_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [UW-1:0]            u_val;
   logic signed [DATA_W:0]   rr, mr, diff;
   logic [DATA_W:0]          abs_rr, abs_mr, abs_diff;
   logic                     div_start, div_busy, div_done;
   logic [DIVD_W-1:0]        div_a, div_q;
   logic [DIVS_W-1:0]        div_b, div_r;
   logic signed [WIDE_W-1:0] s_w, lo_bound, hi_bound, sq;
   logic signed [QW-1:0]     qm, q_next;
   logic [UW:0]              r_sum;
   logic [UW-1:0]            r_next;
   logic                     due, load;

   // clamp the upsample factor to 1..MAX_UPSAMPLE
   always_comb begin
      if (cfg.upsample_factor == '0) begin
         u_val = UW'(1);
      end else if (32'(cfg.upsample_factor) > MAX_UPSAMPLE) begin
         u_val = UW'(MAX_UPSAMPLE);
      end else begin
         u_val = UW'(cfg.upsample_factor);
      end
   end

   assign rr       = {rhi_ff[DATA_W-1], rhi_ff} - {rlo_ff[DATA_W-1], rlo_ff};
   assign mr       = {cfg.model_max[DATA_W-1], cfg.model_max}
                   - {cfg.model_min[DATA_W-1], cfg.model_min};
   assign diff     = {scaled_ff[DATA_W-1], scaled_ff} - {prev_ff[DATA_W-1], prev_ff};
   assign abs_rr   = rr[DATA_W] ? (DATA_W+1)'(-rr) : rr;
   assign abs_mr   = mr[DATA_W] ? (DATA_W+1)'(-mr) : mr;
   assign abs_diff = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;

   assign div_start = (cmd == OP_FAC_START) || (cmd == OP_DIFF_START);
   always_comb begin
      if (cmd == OP_DIFF_START) begin
         div_a = DIVD_W'(abs_diff);
         div_b = DIVS_W'(u_val);
      end else begin
         div_a = {abs_mr, {FRAC_W{1'b0}}};
         div_b = abs_rr;
      end
   end

   drt_div #(.DW(DIVD_W), .VW(DIVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   // window acceptance bounds: one real range beyond each bound
   assign s_w      = WIDE_W'(smp_ff);
   assign lo_bound = 2 * WIDE_W'(cfg.real_min) - WIDE_W'(cfg.real_max);
   assign hi_bound = 2 * WIDE_W'(cfg.real_max) - WIDE_W'(cfg.real_min);
   assign sq       = neg_ff ? -WIDE_W'(div_q) : WIDE_W'(div_q);
   assign due      = (32'(cnt_ff) >= 32'(cfg.recal_interval))
                   && (wh_ff != VAL_MIN) && (wl_ff != VAL_MAX);

   // running floor(j*diff/u) as quotient and remainder
   assign qm     = QW'(div_q);
   assign r_sum  = {1'b0, r_ff} + {1'b0, dr_ff};
   always_comb begin
      if (r_sum >= {1'b0, u_val}) begin
         r_next = UW'(r_sum - {1'b0, u_val});
         q_next = q_ff + dq_ff + QW'(1);
      end else begin
         r_next = r_sum[UW-1:0];
         q_next = q_ff + dq_ff;
      end
   end

   assign load = (cmd == OP_EMIT_PT) || (cmd == OP_EMIT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= RST_GAIN;
         bias_ff      <= RST_BIAS;
         wl_ff        <= VAL_MAX;
         wh_ff        <= VAL_MIN;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (cmd)
            OP_ACCEPT: begin
               if (req_data.first) begin
                  wl_ff        <= VAL_MAX;
                  wh_ff        <= VAL_MIN;
                  cnt_ff       <= '0;
                  have_prev_ff <= 1'b0;
               end
            end
            OP_FAC_ZERO: begin
               gain_ff <= '0;
               bias_ff <= cfg.model_min;
            end
            OP_FAC_BIAS: begin
               gain_ff <= gnew_ff;
               bias_ff <= sat_val(WIDE_W'(cfg.model_min) - (prod_ff >>> FRAC_W));
            end
            OP_WIN: begin
               if ((wl_ff > smp_ff) && (s_w > lo_bound)) begin
                  wl_ff <= smp_ff;
               end
               if ((wh_ff < smp_ff) && (s_w < hi_bound)) begin
                  wh_ff <= smp_ff;
               end
            end
            OP_CHECK: begin
               if (due) begin
                  wl_ff  <= VAL_MAX;
                  wh_ff  <= VAL_MIN;
                  cnt_ff <= CB'(1);
               end else if (cnt_ff != {CB{1'b1}}) begin
                  cnt_ff <= cnt_ff + CB'(1);
               end
            end
            OP_EMIT_LAST: begin
               prev_ff      <= scaled_ff;
               have_prev_ff <= 1'b1;
            end
            default: begin
            end
         endcase
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd)
         OP_ACCEPT: begin
            smp_ff <= req_data.sample;
            rlo_ff <= cfg.real_min;
            rhi_ff <= cfg.real_max;
         end
         OP_FAC_START: begin
            neg_ff <= mr[DATA_W] ^ rr[DATA_W];
         end
         OP_FAC_GAIN: begin
            gnew_ff <= sat_val(sq);
            ma_ff   <= rlo_ff;
            mb_ff   <= sat_val(sq);
         end
         OP_MUL: begin
            prod_ff <= WIDE_W'(ma_ff) * WIDE_W'(mb_ff);
         end
         OP_CHECK: begin
            if (due) begin
               rlo_ff <= wl_ff;
               rhi_ff <= wh_ff;
            end
         end
         OP_SMUL_SET: begin
            ma_ff <= smp_ff;
            mb_ff <= gain_ff;
         end
         OP_SCALE: begin
            scaled_ff <= sat_val((prod_ff >>> FRAC_W) + WIDE_W'(bias_ff));
         end
         OP_DIFF_START: begin
            neg_ff <= diff[DATA_W];
         end
         OP_DIFF_DONE: begin
            // floor division: negative with remainder rounds one further down
            if (neg_ff && (div_r[UW-1:0] != '0)) begin
               dq_ff <= -qm - QW'(1);
               dr_ff <= u_val - div_r[UW-1:0];
            end else if (neg_ff) begin
               dq_ff <= -qm;
               dr_ff <= '0;
            end else begin
               dq_ff <= qm;
               dr_ff <= div_r[UW-1:0];
            end
            q_ff <= '0;
            r_ff <= '0;
            j_ff <= UW'(1);
         end
         OP_EMIT_PT: begin
            q_ff <= q_next;
            r_ff <= r_next;
            j_ff <= j_ff + UW'(1);
            rsp_ff.value        <= prev_ff + DATA_W'(q_next);
            rsp_ff.interpolated <= 1'b1;
            rsp_ff.last         <= 1'b0;
         end
         OP_EMIT_LAST: begin
            rsp_ff.value        <= scaled_ff;
            rsp_ff.interpolated <= 1'b0;
            rsp_ff.last         <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.rr_zero     = (rr == '0);
   assign status.due         = due;
   assign status.need_interp = have_prev_ff && (u_val > UW'(1));
   assign status.last_pt     = (j_ff == u_val - UW'(1));
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign status.div_done    = div_done;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_EMIT_PT) |-> (r_ff < u_val) && (dr_ff < u_val))
      else $error("interpolation remainder out of range");

   a_prev_set: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_EMIT_LAST) |=> have_prev_ff && rsp_valid_ff && rsp_ff.last)
      else $error("final word not recorded");

endmodule

[sv/drt_ctrl.sv]
// ----------------------------------------------------------------------------
// drt_ctrl
// sequencer: factor loads, drift recalculation, scaling and word emission
// ----------------------------------------------------------------------------
module drt_ctrl
   import drt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_first,
   input  logic          drift_enable,
   input  dp_status_type status,
   output dp_op_type     cmd,
   output logic          req_stall
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FAC_START,
      S_DIV_WAIT,
      S_FAC_GAIN,
      S_FAC_MUL,
      S_FAC_BIAS,
      S_WIN,
      S_CHECK,
      S_SMUL_SET,
      S_SMUL,
      S_SCALE,
      S_DIFF_START,
      S_DIFF_WAIT,
      S_DIFF_DONE,
      S_EMIT_PT,
      S_EMIT_LAST
   } state_type;

   state_type state_ff, state_in;
   logic      recal_ff, recal_in;
   state_type after_load;

   assign after_load = drift_enable ? S_WIN : S_SMUL_SET;

   always_comb begin
      state_in = state_ff;
      recal_in = recal_ff;
      cmd      = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = OP_ACCEPT;
               recal_in = 1'b0;
               state_in = req_first ? S_FAC_START : after_load;
            end
         end
         S_FAC_START: begin
            if (!status.rr_zero) begin
               cmd      = OP_FAC_START;
               state_in = S_DIV_WAIT;
            end else if (recal_ff) begin
               // flat window keeps the old factors
               state_in = S_SMUL_SET;
            end else begin
               cmd      = OP_FAC_ZERO;
               state_in = after_load;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_FAC_GAIN;
            end
         end
         S_FAC_GAIN: begin
            cmd      = OP_FAC_GAIN;
            state_in = S_FAC_MUL;
         end
         S_FAC_MUL: begin
            cmd      = OP_MUL;
            state_in = S_FAC_BIAS;
         end
         S_FAC_BIAS: begin
            cmd      = OP_FAC_BIAS;
            state_in = recal_ff ? S_SMUL_SET : after_load;
         end
         S_WIN: begin
            cmd      = OP_WIN;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd = OP_CHECK;
            if (status.due) begin
               recal_in = 1'b1;
               state_in = S_FAC_START;
            end else begin
               state_in = S_SMUL_SET;
            end
         end
         S_SMUL_SET: begin
            cmd      = OP_SMUL_SET;
            state_in = S_SMUL;
         end
         S_SMUL: begin
            cmd      = OP_MUL;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd      = OP_SCALE;
            state_in = S_DIFF_START;
         end
         S_DIFF_START: begin
            if (status.need_interp) begin
               cmd      = OP_DIFF_START;
               state_in = S_DIFF_WAIT;
            end else begin
               state_in = S_EMIT_LAST;
            end
         end
         S_DIFF_WAIT: begin
            if (status.div_done) begin
               state_in = S_DIFF_DONE;
            end
         end
         S_DIFF_DONE: begin
            cmd      = OP_DIFF_DONE;
            state_in = S_EMIT_PT;
         end
         S_EMIT_PT: begin
            if (status.out_free) begin
               cmd = OP_EMIT_PT;
               if (status.last_pt) begin
                  state_in = S_EMIT_LAST;
               end
            end
         end
         S_EMIT_LAST: begin
            if (status.out_free) begin
               cmd      = OP_EMIT_LAST;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         recal_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         recal_ff <= recal_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_EMIT_PT || cmd == OP_EMIT_LAST) |-> status.out_free)
      else $error("word emitted into a full output register");

   a_gain_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FAC_GAIN) |=> (state_ff == S_FAC_MUL) ##1 (state_ff == S_FAC_BIAS))
      else $error("factor sequence broken");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_ACCEPT) |=> req_stall)
      else $error("second word accepted while busy");

endmodule
